### design/chi_pkg.sv
// Shared constants, types and helpers for the cubic Hermite joint interpolator.
package chi_pkg;

    localparam int CHI_FRAC_BITS  = 16;
    localparam int CHI_DATA_WIDTH = 32;

    typedef struct packed {
        logic neg;
        logic ovf;
        logic bad;
    } t_flags;

    function automatic int chi_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

### design/chi_mul.sv
// Two-stage multiply-add: signed wide A times unsigned B plus signed C, split into B-wide digits.
module chi_mul #(
    parameter int AW = 33,
    parameter int W  = 32,
    parameter int CW = 1,
    parameter int PW = 65
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [AW-1:0] i_a,
    input  logic        [W-1:0]  i_b,
    input  logic signed [CW-1:0] i_c,
    output logic signed [PW-1:0] o_p
);

    localparam int NCH = (AW + W - 1) / W;
    localparam int AXW = NCH * W;
    localparam int PPW = 2 * W + 2;

    logic signed [AXW-1:0] a_ext;
    logic signed [PPW-1:0] r_pp [NCH];
    logic signed [CW-1:0]  r_c;
    logic signed [PW-1:0]  n_sum;
    logic signed [PW-1:0]  r_p;

    assign a_ext = AXW'(i_a);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NCH; i++) begin
                r_pp[i] <= (i == NCH - 1)
                    ? $signed(a_ext[i*W +: W]) * $signed({1'b0, i_b})
                    : $signed({1'b0, a_ext[i*W +: W]}) * $signed({1'b0, i_b});
            end
            r_c <= i_c;
        end
    end

    always_comb begin
        n_sum = PW'(r_c);
        for (int i = 0; i < NCH; i++) begin
            n_sum = n_sum + (PW'(r_pp[i]) <<< (i * W));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_sum;
        end
    end

    assign o_p = r_p;

endmodule

### design/chi_div.sv
// Pipelined restoring divider: one quotient bit per stage, flags travel alongside.
module chi_div #(
    parameter int W   = 32,
    parameter int DVW = 144
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [DVW-1:0]        i_rem,
    input  logic [DVW-1:0]        i_div,
    input  chi_pkg::t_flags       i_flags,
    output logic                  o_vld,
    output logic [W-1:0]          o_q,
    output logic                  o_remnz,
    output chi_pkg::t_flags       o_flags
);

    import chi_pkg::*;

    logic [DVW-1:0] w_rin [W];
    logic [DVW-1:0] w_din [W];
    logic [W-1:0]   w_qin [W];
    t_flags         w_fin [W];
    logic           w_vin [W];

    logic           n_ge  [W];
    logic [DVW-1:0] n_rem [W];
    logic [W-1:0]   n_q   [W];

    logic [DVW-1:0] r_rem [W];
    logic [DVW-1:0] r_div [W];
    logic [W-1:0]   r_q   [W];
    t_flags         r_fl  [W];
    logic           r_v   [W];

    assign w_rin[0] = i_rem;
    assign w_din[0] = i_div;
    assign w_qin[0] = '0;
    assign w_fin[0] = i_flags;
    assign w_vin[0] = i_vld;

    for (genvar s = 1; s < W; s++) begin : g_link
        assign w_rin[s] = r_rem[s-1];
        assign w_din[s] = r_div[s-1];
        assign w_qin[s] = r_q[s-1];
        assign w_fin[s] = r_fl[s-1];
        assign w_vin[s] = r_v[s-1];
    end

    always_comb begin
        for (int s = 0; s < W; s++) begin
            n_ge[s]  = w_rin[s] >= (w_din[s] << (W - 1 - s));
            n_rem[s] = n_ge[s] ? w_rin[s] - (w_din[s] << (W - 1 - s)) : w_rin[s];
            n_q[s]   = w_qin[s] | (W'(n_ge[s]) << (W - 1 - s));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '{default: 1'b0};
        end else if (i_en) begin
            for (int s = 0; s < W; s++) begin
                r_v[s] <= w_vin[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < W; s++) begin
                r_rem[s] <= n_rem[s];
                r_div[s] <= w_din[s];
                r_q[s]   <= n_q[s];
                r_fl[s]  <= w_fin[s];
            end
        end
    end

    assign o_vld   = r_v[W-1];
    assign o_q     = r_q[W-1];
    assign o_remnz = |r_rem[W-1];
    assign o_flags = r_fl[W-1];

endmodule

### design/cubic_hermite_joint_interp.sv
// Top level of the cubic Hermite joint interpolator.
// Usage:
//   Input channel: i_valid / o_stall with elapsed, duration, start and end position and
//   velocity, all Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS. An item is taken when i_valid is
//   high and o_stall is low.
//   Output channel: o_valid / i_stall with position (floored, saturated), saturated and
//   bad_duration. A result is taken when o_valid is high and i_stall is low.
//   Throughput: one item per cycle while the receiver takes results.
//   Pipeline: one input register, five multiply-add stages evaluating the cubic in
//   Horner form, a registered sign and range check, DATA_WIDTH divider stages, one
//   output register. The divider's one-bit-per-stage restoring loop sets the depth.
//   A stalled result holds the whole pipeline in place; o_stall rises in the same
//   cycle, so no item is lost or repeated. Items in flight stay ordered.
//   Reset (synchronous, active low) clears every valid bit; data registers keep
//   their contents. There is no configuration and no state between items.
module cubic_hermite_joint_interp #(
    parameter int FRAC_BITS  = chi_pkg::CHI_FRAC_BITS,
    parameter int DATA_WIDTH = chi_pkg::CHI_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic        [DATA_WIDTH-1:0] i_elapsed,
    input  logic        [DATA_WIDTH-1:0] i_duration,
    input  logic signed [DATA_WIDTH-1:0] i_start_pos,
    input  logic signed [DATA_WIDTH-1:0] i_end_pos,
    input  logic signed [DATA_WIDTH-1:0] i_start_vel,
    input  logic signed [DATA_WIDTH-1:0] i_end_vel,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_position,
    output logic                         o_saturated,
    output logic                         o_bad_duration
);

    import chi_pkg::*;

    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int DPW  = W + 1;
    localparam int VSW  = W + 1;
    localparam int WNW  = W + 2;
    localparam int T3W  = W + 3;
    localparam int P0W  = W + F;
    localparam int CAW  = W + F + 2;
    localparam int D2W  = 2 * W + 1;
    localparam int TW   = T3W + W;
    localparam int WDW  = WNW + W;
    localparam int A3W  = chi_max(VSW + W, CAW) + 1;
    localparam int GW   = chi_max(2 * W, P0W) + 1;
    localparam int D3W  = D2W + W;
    localparam int A2W  = chi_max(WDW + W, TW + F) + 1;
    localparam int GDW  = GW + W;
    localparam int GD2W = GDW + W;
    localparam int GD3W = GD2W + W;
    localparam int H1W  = chi_max(A3W + W, A2W) + 1;
    localparam int H2W  = H1W + W;
    localparam int NW   = chi_max(H2W + W, GD3W) + 1;
    localparam int DVW  = chi_max(NW, 4 * W + F);

    localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] POS_MIN = {1'b1, {(W-1){1'b0}}};

    logic en;

    logic signed [DPW-1:0] n_dp;
    logic signed [T3W-1:0] r_dp3;
    logic signed [VSW-1:0] r_vs;
    logic signed [WNW-1:0] r_wn;
    logic signed [P0W-1:0] r_p0s;
    logic signed [CAW-1:0] r_ca;
    logic signed [W-1:0]   r_v0;
    logic        [W-1:0]   r_e   [9];
    logic        [W-1:0]   r_d   [7];
    logic                  r_bad [11];
    logic                  r_v   [11];

    logic signed [D2W-1:0]  m_d2;
    logic signed [TW-1:0]   m_t;
    logic signed [A3W-1:0]  m_a3;
    logic signed [GW-1:0]   m_g;
    logic signed [WDW-1:0]  m_wd;
    logic signed [D3W-1:0]  m_d3;
    logic signed [A2W-1:0]  m_a2;
    logic signed [GDW-1:0]  m_gd;
    logic signed [H1W-1:0]  m_h1;
    logic signed [GD2W-1:0] m_gd2;
    logic signed [H2W-1:0]  m_h2;
    logic signed [GD3W-1:0] m_gd3;
    logic signed [NW-1:0]   m_n;

    logic signed [TW+F-1:0] t_sh;
    logic signed [A3W-1:0]  r_a3d [2];
    logic        [3*W-1:0]  r_d3d [6];

    logic           r_neg;
    logic [DVW-1:0] r_mag;
    logic [DVW-1:0] r_div;
    logic           r_ab;
    logic           r_av;

    logic [DVW-1:0] n_lim;
    logic [DVW-1:0] r_fmag;
    logic [DVW-1:0] r_fdiv;
    t_flags         r_fl;
    logic           r_fv;

    logic           d_vld;
    logic [W-1:0]   d_q;
    logic           d_remnz;
    t_flags         d_fl;

    logic [W-1:0]   n_pos;
    logic [W-1:0]   r_pos;
    logic           r_sat;
    logic           r_obad;
    logic           r_ovld;

    assign en      = !r_ovld || !i_stall;
    assign o_stall = !en;

    assign n_dp = DPW'(i_end_pos) - DPW'(i_start_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '{default: 1'b0};
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < 11; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dp3    <= (T3W'(n_dp) <<< 1) + T3W'(n_dp);
            r_vs     <= VSW'(i_start_vel) + VSW'(i_end_vel);
            r_wn     <= -(WNW'(i_start_vel) <<< 1) - WNW'(i_end_vel);
            r_p0s    <= {i_start_pos, {F{1'b0}}};
            r_ca     <= -(CAW'(n_dp) <<< (F + 1));
            r_v0     <= i_start_vel;
            r_e[0]   <= i_elapsed;
            r_d[0]   <= i_duration;
            r_bad[0] <= (i_duration == '0);
            for (int k = 1; k < 9; k++) begin
                r_e[k] <= r_e[k-1];
            end
            for (int k = 1; k < 7; k++) begin
                r_d[k] <= r_d[k-1];
            end
            for (int k = 1; k < 11; k++) begin
                r_bad[k] <= r_bad[k-1];
            end
            r_a3d[0] <= m_a3;
            r_a3d[1] <= r_a3d[0];
            r_d3d[0] <= m_d3[3*W-1:0];
            for (int k = 1; k < 6; k++) begin
                r_d3d[k] <= r_d3d[k-1];
            end
        end
    end

    chi_mul #(.AW(W + 1), .W(W), .CW(1), .PW(D2W)) u_mul_d2 (
        .i_clk(i_clk), .i_en(en), .i_a({1'b0, r_d[0]}), .i_b(r_d[0]),
        .i_c(1'b0), .o_p(m_d2)
    );

    chi_mul #(.AW(T3W), .W(W), .CW(1), .PW(TW)) u_mul_t (
        .i_clk(i_clk), .i_en(en), .i_a(r_dp3), .i_b(r_d[0]),
        .i_c(1'b0), .o_p(m_t)
    );

    chi_mul #(.AW(VSW), .W(W), .CW(CAW), .PW(A3W)) u_mul_a3 (
        .i_clk(i_clk), .i_en(en), .i_a(r_vs), .i_b(r_d[0]),
        .i_c(r_ca), .o_p(m_a3)
    );

    chi_mul #(.AW(W), .W(W), .CW(P0W), .PW(GW)) u_mul_g (
        .i_clk(i_clk), .i_en(en), .i_a(r_v0), .i_b(r_e[0]),
        .i_c(r_p0s), .o_p(m_g)
    );

    chi_mul #(.AW(WNW), .W(W), .CW(1), .PW(WDW)) u_mul_wd (
        .i_clk(i_clk), .i_en(en), .i_a(r_wn), .i_b(r_d[0]),
        .i_c(1'b0), .o_p(m_wd)
    );

    assign t_sh = {m_t, {F{1'b0}}};

    chi_mul #(.AW(D2W), .W(W), .CW(1), .PW(D3W)) u_mul_d3 (
        .i_clk(i_clk), .i_en(en), .i_a(m_d2), .i_b(r_d[2]),
        .i_c(1'b0), .o_p(m_d3)
    );

    chi_mul #(.AW(WDW), .W(W), .CW(TW + F), .PW(A2W)) u_mul_a2 (
        .i_clk(i_clk), .i_en(en), .i_a(m_wd), .i_b(r_d[2]),
        .i_c(t_sh), .o_p(m_a2)
    );

    chi_mul #(.AW(GW), .W(W), .CW(1), .PW(GDW)) u_mul_gd (
        .i_clk(i_clk), .i_en(en), .i_a(m_g), .i_b(r_d[2]),
        .i_c(1'b0), .o_p(m_gd)
    );

    chi_mul #(.AW(A3W), .W(W), .CW(A2W), .PW(H1W)) u_mul_h1 (
        .i_clk(i_clk), .i_en(en), .i_a(r_a3d[1]), .i_b(r_e[4]),
        .i_c(m_a2), .o_p(m_h1)
    );

    chi_mul #(.AW(GDW), .W(W), .CW(1), .PW(GD2W)) u_mul_gd2 (
        .i_clk(i_clk), .i_en(en), .i_a(m_gd), .i_b(r_d[4]),
        .i_c(1'b0), .o_p(m_gd2)
    );

    chi_mul #(.AW(H1W), .W(W), .CW(1), .PW(H2W)) u_mul_h2 (
        .i_clk(i_clk), .i_en(en), .i_a(m_h1), .i_b(r_e[6]),
        .i_c(1'b0), .o_p(m_h2)
    );

    chi_mul #(.AW(GD2W), .W(W), .CW(1), .PW(GD3W)) u_mul_gd3 (
        .i_clk(i_clk), .i_en(en), .i_a(m_gd2), .i_b(r_d[6]),
        .i_c(1'b0), .o_p(m_gd3)
    );

    chi_mul #(.AW(H2W), .W(W), .CW(GD3W), .PW(NW)) u_mul_n (
        .i_clk(i_clk), .i_en(en), .i_a(m_h2), .i_b(r_e[8]),
        .i_c(m_gd3), .o_p(m_n)
    );

    assign n_lim = r_div << (W - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
            r_fv <= 1'b0;
        end else if (en) begin
            r_av <= r_v[10];
            r_fv <= r_av;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_neg  <= m_n[NW-1];
            r_mag  <= DVW'(m_n[NW-1] ? -m_n : m_n);
            r_div  <= DVW'({r_d3d[5], {F{1'b0}}});
            r_ab   <= r_bad[10];
            r_fmag <= r_mag;
            r_fdiv <= r_div;
            r_fl.neg <= r_neg;
            r_fl.ovf <= r_neg ? (r_mag > n_lim) : (r_mag >= n_lim);
            r_fl.bad <= r_ab;
        end
    end

    chi_div #(.W(W), .DVW(DVW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_vld(r_fv),
        .i_rem(r_fmag), .i_div(r_fdiv), .i_flags(r_fl),
        .o_vld(d_vld), .o_q(d_q), .o_remnz(d_remnz), .o_flags(d_fl)
    );

    always_comb begin
        if (d_fl.bad) begin
            n_pos = '0;
        end else if (d_fl.ovf) begin
            n_pos = d_fl.neg ? POS_MIN : POS_MAX;
        end else if (d_fl.neg) begin
            n_pos = ~d_q + W'(!d_remnz);
        end else begin
            n_pos = d_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pos  <= n_pos;
            r_sat  <= !d_fl.bad && d_fl.ovf;
            r_obad <= d_fl.bad;
        end
    end

    assign o_valid        = r_ovld;
    assign o_position     = r_pos;
    assign o_saturated    = r_sat;
    assign o_bad_duration = r_obad;

`ifndef NO_ASSERTIONS
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_saturated && o_bad_duration))
        else $error("saturated and bad_duration both set");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_duration) |-> (o_position == '0))
        else $error("bad duration with nonzero position");

    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_position == POS_MAX || o_position == POS_MIN))
        else $error("saturated position not at a rail");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("input not stalled while result held");
`endif

endmodule

### tb/sv/testbench.sv
// Testbench for the cubic Hermite joint interpolator: directed and random items checked
// against table values or an exact wide-integer position predictor.
`timescale 1ns / 1ps

module testbench;
    import chi_pkg::*;

    localparam int FB = CHI_FRAC_BITS;
    localparam int DW = CHI_DATA_WIDTH;
    localparam int LATENCY = DW + 14;

    typedef logic signed [383:0] t_wide;

    typedef struct {
        logic        [DW-1:0] elapsed;
        logic        [DW-1:0] duration;
        logic signed [DW-1:0] start_pos;
        logic signed [DW-1:0] end_pos;
        logic signed [DW-1:0] start_vel;
        logic signed [DW-1:0] end_vel;
    } t_joint;

    typedef struct {
        logic signed [DW-1:0] position;
        logic                 saturated;
        logic                 bad_duration;
    } t_pos;

    typedef struct {
        t_joint joint;
        logic   typed;
        t_pos   want;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic        [DW-1:0] i_elapsed = '0;
    logic        [DW-1:0] i_duration = '0;
    logic signed [DW-1:0] i_start_pos = '0;
    logic signed [DW-1:0] i_end_pos = '0;
    logic signed [DW-1:0] i_start_vel = '0;
    logic signed [DW-1:0] i_end_vel = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic signed [DW-1:0] o_position;
    logic                 o_saturated;
    logic                 o_bad_duration;

    t_pos   pending_positions[$];
    t_row   rows[$];
    int     error_count = 0;
    int     accepted_count = 0;
    int     hold_left = 0;
    bit     hold_done = 0;
    t_joint cur;
    t_pos   cur_want;
    logic   cur_typed;

    cubic_hermite_joint_interp uut (.*);

    always #5 i_clk = ~i_clk;

    function automatic t_pos hermite_position(t_joint j);
        t_pos  r;
        t_wide e, d, p0, p1, v0, v1, s, dp, num, den, q, hi, lo;
        e = j.elapsed;
        d = j.duration;
        p0 = j.start_pos;
        p1 = j.end_pos;
        v0 = j.start_vel;
        v1 = j.end_vel;
        r.saturated = 1'b0;
        r.bad_duration = 1'b0;
        r.position = '0;
        if (d == 0) begin
            r.bad_duration = 1'b1;
            return r;
        end
        s = t_wide'(1) <<< FB;
        hi = (t_wide'(1) <<< (DW-1)) - 1;
        lo = -(t_wide'(1) <<< (DW-1));
        dp = p1 - p0;
        num = s * (p0*d*d*d + 3*dp*e*e*d - 2*dp*e*e*e)
            + v0*e*d*d*d - (2*v0 + v1)*d*d*e*e + (v0 + v1)*d*e*e*e;
        den = s*d*d*d;
        q = num / den;
        if (num < 0 && (num % den) != 0) q = q - 1;
        if (q > hi) begin
            r.position = {1'b0, {(DW-1){1'b1}}};
            r.saturated = 1'b1;
        end else if (q < lo) begin
            r.position = {1'b1, {(DW-1){1'b0}}};
            r.saturated = 1'b1;
        end else begin
            r.position = q[DW-1:0];
        end
        return r;
    endfunction

    function automatic logic [DW-1:0] rand_field(bit small_range);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return small_range ? DW'($urandom_range(0, 32'h0004_0000))
                                  : DW'($urandom_range(0, 32'h0100_0000));
            2: return -DW'($urandom_range(0, 32'h0004_0000));
            default: return DW'($urandom_range(0, 32'h0002_0000));
        endcase
    endfunction

    function automatic t_joint random_joint();
        t_joint j;
        j.duration = ($urandom_range(0, 9) == 0) ? DW'($urandom) :
                     DW'($urandom_range(1, 32'h0008_0000));
        if ($urandom_range(0, 49) == 0) j.duration = '0;
        case ($urandom_range(0, 9))
            0: j.elapsed = $urandom;
            1: j.elapsed = j.duration;
            default: j.elapsed = DW'($urandom_range(0, j.duration));
        endcase
        j.start_pos = rand_field(0);
        j.end_pos = rand_field(0);
        j.start_vel = rand_field(1);
        j.end_vel = rand_field(1);
        return j;
    endfunction

    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void add_row(t_joint j, logic typed, t_pos want);
        t_row r;
        r.joint = j;
        r.typed = typed;
        r.want = want;
        rows.insert(rows.size(), r);
    endfunction

    function automatic t_joint mk(logic [DW-1:0] e, d, p0, p1, v0, v1);
        t_joint j;
        j.elapsed = e;
        j.duration = d;
        j.start_pos = p0;
        j.end_pos = p1;
        j.start_vel = v0;
        j.end_vel = v1;
        return j;
    endfunction

    function automatic t_pos mkp(logic [DW-1:0] p, logic s, logic b);
        t_pos r;
        r.position = p;
        r.saturated = s;
        r.bad_duration = b;
        return r;
    endfunction

    function automatic void build_directed();
        t_pos none;
        none = mkp(0, 0, 0);
        add_row(mk(32'h0001_0000, 0, 32'h7fff_ffff, 5, 6, 7), 1, mkp(0, 0, 1));
        add_row(mk('1, 0, '1, '1, '1, '1), 1, mkp(0, 0, 1));
        add_row(mk(0, 32'h0001_0000, 32'h0002_8000, 0, 32'h0001_0000, 0), 1,
                mkp(32'h0002_8000, 0, 0));
        add_row(mk(0, '1, 32'h8000_0000, 32'h7fff_ffff, '1, 0), 1,
                mkp(32'h8000_0000, 0, 0));
        add_row(mk(0, 1, 32'h7fff_ffff, 32'h8000_0000, 0, '1), 1,
                mkp(32'h7fff_ffff, 0, 0));
        add_row(mk(32'h0002_0000, 32'h0002_0000, 1, -32'sd7, 32'h1234, 32'h4321), 1,
                mkp(-32'sd7, 0, 0));
        add_row(mk('1, '1, 32'h8000_0000, 32'h7fff_ffff, 0, 0), 1,
                mkp(32'h7fff_ffff, 0, 0));
        add_row(mk(32'h0000_8000, 32'h0001_0000, 0, 32'h0001_0000, 0, 0), 0, none);
        add_row(mk(32'h0000_4000, 32'h0001_0000, -32'sd3, 32'sd4, -32'sd9, 32'sd1), 0, none);
        add_row(mk('1, 1, 0, 32'h7fff_ffff, 0, 0), 0, none);
        add_row(mk('1, 1, 0, 32'h8000_0000, 0, 0), 0, none);
        add_row(mk('1, 32'h0001_0000, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff), 0, none);
        add_row(mk('1, 32'h0001_0000, 0, 0, 32'h8000_0000, 32'h8000_0000), 0, none);
        add_row(mk('1, '1, '1, '1, '1, '1), 0, none);
        add_row(mk(32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 32'h0001_0000), 0,
                none);
        add_row(mk(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                   32'h5555_5555, 32'haaaa_aaaa), 0, none);
        add_row(mk(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                   32'haaaa_aaaa, 32'h5555_5555), 0, none);
    endfunction

    task automatic send(t_joint j, logic typed, t_pos want);
        i_elapsed = j.elapsed;
        i_duration = j.duration;
        i_start_pos = j.start_pos;
        i_end_pos = j.end_pos;
        i_start_vel = j.start_vel;
        i_end_vel = j.end_vel;
        cur = j;
        cur_typed = typed;
        cur_want = want;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        repeat (gap_cycles()) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_pos exp_pos;
        if (i_rst_n && i_valid && !o_stall) begin
            exp_pos = hermite_position(cur);
            if (cur_typed && (exp_pos.position !== cur_want.position ||
                              exp_pos.saturated !== cur_want.saturated ||
                              exp_pos.bad_duration !== cur_want.bad_duration)) begin
                $display("%0t predictor disagrees with table: expected %h %b %b got %h %b %b",
                         $time, cur_want.position, cur_want.saturated, cur_want.bad_duration,
                         exp_pos.position, exp_pos.saturated, exp_pos.bad_duration);
                error_count++;
            end
            pending_positions.insert(pending_positions.size(),
                                     cur_typed ? cur_want : exp_pos);
            accepted_count++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_positions.size() == 0) begin
                $display("%0t unexpected result: position %h", $time, o_position);
                error_count++;
            end else begin
                exp_pos = pending_positions.pop_front();
                if (o_position !== exp_pos.position) begin
                    $display("%0t position: expected %h actual %h", $time,
                             exp_pos.position, o_position);
                    error_count++;
                end
                if (o_saturated !== exp_pos.saturated) begin
                    $display("%0t saturated: expected %b actual %b", $time,
                             exp_pos.saturated, o_saturated);
                    error_count++;
                end
                if (o_bad_duration !== exp_pos.bad_duration) begin
                    $display("%0t bad_duration: expected %b actual %b", $time,
                             exp_pos.bad_duration, o_bad_duration);
                    error_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!hold_done && accepted_count >= 600) begin
            hold_done = 1;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall = 1'b1;
        end else if (accepted_count > 1200 && accepted_count < 1500) begin
            i_stall = 1'b0;
        end else begin
            i_stall = ($urandom_range(0, 99) < 25) ? 1'b1 :
                      ($urandom_range(0, 199) == 0 ? 1'b1 : 1'b0);
        end
    end

    initial begin
        t_pos none;
        none = mkp(0, 0, 0);
        build_directed();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (rows[k]) send(rows[k].joint, rows[k].typed, rows[k].want);
        repeat (2000) send(random_joint(), 1'b0, none);
        i_valid = 1'b0;
        while (pending_positions.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
design/chi_pkg.sv
design/chi_mul.sv
design/chi_div.sv
design/cubic_hermite_joint_interp.sv
tb/sv/testbench.sv
